// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the trie stream word counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TSWC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must be followed by another in the next cycle.
`define TSWC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tswc_pkg.sv
// Types, codes and defaults shared by the trie stream word counter.
package tswc_pkg;

    localparam int NODE_SLOTS_DEF = 1024;
    localparam int ACTIVE_MAX_DEF = 16;

    // Input item kinds
    localparam logic [1:0] IK_DICT   = 2'd0;
    localparam logic [1:0] IK_STREAM = 2'd1;
    localparam logic [1:0] IK_READ   = 2'd2;

    // Result kinds
    localparam logic [1:0] RK_ACK     = 2'd0;
    localparam logic [1:0] RK_MATCH   = 2'd1;
    localparam logic [1:0] RK_NOMATCH = 2'd2;
    localparam logic [1:0] RK_COUNT   = 2'd3;

    // Status codes
    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_FULL = 2'd1;
    localparam logic [1:0] STS_LONG = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] symbol;
        logic       word_end;
        logic [9:0] query_node;
    } t_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [9:0]  result_node;
        logic [31:0] result_count;
        logic [1:0]  status;
        logic        last_result;
    } t_res;

    // One entry of the count memory
    typedef struct packed {
        logic        term;
        logic [31:0] cnt;
    } t_cnt_entry;

    typedef enum logic [2:0] {
        CNT_NONE,
        CNT_READ,
        CNT_BUMP,
        CNT_MARK,
        CNT_INIT
    } t_cnt_op;

    typedef struct packed {
        t_cnt_op op;
        logic    init_term;
    } t_cnt_ctl;

endpackage

// File: hw/rtl/tswc_count_unit.sv
// Terminal flag and occurrence count memory with its read-modify-write logic.
module tswc_count_unit #(
    parameter int NODE_SLOTS = tswc_pkg::NODE_SLOTS_DEF
) (
    input  logic                      i_clk,
    input  tswc_pkg::t_cnt_ctl        i_ctl,
    input  logic [$clog2(NODE_SLOTS)-1:0] i_addr,
    output tswc_pkg::t_cnt_entry      o_q
);
    tswc_pkg::t_cnt_entry r_mem [NODE_SLOTS];
    tswc_pkg::t_cnt_entry r_q;
    logic [31:0]          sat_cnt;

    // Saturating increment of the last entry read
    assign sat_cnt = (r_q.cnt == 32'hFFFF_FFFF) ? r_q.cnt : r_q.cnt + 32'd1;

    // Read, bump, mark and init share one port; the bumped value is returned
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            tswc_pkg::CNT_READ: begin
                r_q <= r_mem[i_addr];
            end
            tswc_pkg::CNT_BUMP: begin
                r_mem[i_addr] <= '{term: 1'b1, cnt: sat_cnt};
                r_q           <= '{term: 1'b1, cnt: sat_cnt};
            end
            tswc_pkg::CNT_MARK: begin
                r_mem[i_addr] <= '{term: 1'b1, cnt: r_q.cnt};
            end
            tswc_pkg::CNT_INIT: begin
                r_mem[i_addr] <= '{term: i_ctl.init_term, cnt: 32'd0};
            end
            default: begin
            end
        endcase
    end

    assign o_q = r_q;

endmodule

// File: hw/rtl/trie_stream_word_counter.sv
// Trie stream word counter: dictionary load, stream matching and count reads.
// Dictionary: child search from the cursor; a miss adds a node, relinking a non-root
// parent; a found word end is marked terminal; refused characters skip the search.
// Stream: active matches, then the root, are searched; survivor counts are read and
// bumped if terminal, then the final strobe. Count read: root or unused nodes give 0.
// One item at a time, receiver cannot stall; reset clears control state only.
module trie_stream_word_counter #(
    parameter int NODE_SLOTS = tswc_pkg::NODE_SLOTS_DEF,
    parameter int ACTIVE_MAX = tswc_pkg::ACTIVE_MAX_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  tswc_pkg::t_item i_item,
    output logic            o_valid,
    output tswc_pkg::t_res  o_res
);
`include "assert_macros.svh"

    localparam int NW = $clog2(NODE_SLOTS);
    localparam int UW = $clog2(NODE_SLOTS + 1);
    localparam int AW = $clog2(ACTIVE_MAX);
    localparam int CW = $clog2(ACTIVE_MAX + 1);

    typedef struct packed {
        logic [7:0]    letter;
        logic [NW-1:0] fc;
        logic [NW-1:0] sib;
    } t_link;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_PAR   = 11'b000_0000_0010,
        S_CHK   = 11'b000_0000_0100,
        S_SIB   = 11'b000_0000_1000,
        S_WDONE = 11'b000_0001_0000,
        S_DLINK = 11'b000_0010_0000,
        S_DTRM  = 11'b000_0100_0000,
        S_CNT   = 11'b000_1000_0000,
        S_CNT1  = 11'b001_0000_0000,
        S_CNT2  = 11'b010_0000_0000,
        S_QRD   = 11'b100_0000_0000
    } t_state;

    t_state         r_state, n_state;
    logic [1:0]     r_kind, n_kind;
    logic [7:0]     r_sym, n_sym;
    logic           r_end, n_end;
    logic [9:0]     r_q, n_q;
    logic [UW-1:0]  r_used, n_used;
    logic [NW-1:0]  r_cursor, n_cursor;
    logic [CW-1:0]  r_depth, n_depth;
    logic [1:0]     r_werr, n_werr;
    logic [NW-1:0]  r_root_fc, n_root_fc;
    logic [NW-1:0]  r_act [ACTIVE_MAX];
    logic [NW-1:0]  n_act [ACTIVE_MAX];
    logic [CW-1:0]  r_ac, n_ac;
    logic [CW-1:0]  r_i, n_i;
    logic [CW-1:0]  r_n, n_n;
    logic [CW-1:0]  r_j, n_j;
    logic [NW-1:0]  r_c, n_c;
    t_link          r_par, n_par;
    logic           r_found, n_found;
    logic [NW-1:0]  r_new, n_new;
    logic           r_pend_v, n_pend_v;
    logic [NW-1:0]  r_pend_node, n_pend_node;
    logic [31:0]    r_pend_cnt, n_pend_cnt;
    logic           r_valid, n_valid;
    tswc_pkg::t_res r_res, n_res;

    // Link memory
    t_link          r_link_mem [NODE_SLOTS];
    t_link          r_link_q;
    logic           link_rd;
    logic [NW-1:0]  link_rd_addr;
    logic           link_wr;
    logic [NW-1:0]  link_wr_addr;
    t_link          link_wr_data;

    // Count unit
    tswc_pkg::t_cnt_ctl   cnt_ctl;
    logic [NW-1:0]        cnt_addr;
    tswc_pkg::t_cnt_entry cnt_q;

    logic [NW-1:0]  walk_from;
    logic           walk_go;
    logic [CW-1:0]  nxt_i;
    logic [CW-1:0]  surv_n;
    logic [NW-1:0]  new_node;
    logic [NW-1:0]  parent_fc;
    logic [NW-1:0]  act_j;

    tswc_count_unit #(
        .NODE_SLOTS(NODE_SLOTS)
    ) u_count (
        .i_clk  (i_clk),
        .i_ctl  (cnt_ctl),
        .i_addr (cnt_addr),
        .o_q    (cnt_q)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_res    = r_res;
    assign nxt_i    = r_i + CW'(1);
    assign new_node = NW'(r_used);
    assign act_j    = r_act[r_j[AW-1:0]];
    assign parent_fc = (r_cursor == '0) ? r_root_fc : r_par.fc;

    // Link memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (link_wr) begin
            r_link_mem[link_wr_addr] <= link_wr_data;
        end
        if (link_rd) begin
            r_link_q <= r_link_mem[link_rd_addr];
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_sym       = r_sym;
        n_end       = r_end;
        n_q         = r_q;
        n_used      = r_used;
        n_cursor    = r_cursor;
        n_depth     = r_depth;
        n_werr      = r_werr;
        n_root_fc   = r_root_fc;
        n_act       = r_act;
        n_ac        = r_ac;
        n_i         = r_i;
        n_n         = r_n;
        n_j         = r_j;
        n_c         = r_c;
        n_par       = r_par;
        n_found     = r_found;
        n_new       = r_new;
        n_pend_v    = r_pend_v;
        n_pend_node = r_pend_node;
        n_pend_cnt  = r_pend_cnt;
        n_valid     = 1'b0;
        n_res       = r_res;
        link_rd      = 1'b0;
        link_rd_addr = '0;
        link_wr      = 1'b0;
        link_wr_addr = '0;
        link_wr_data = '0;
        cnt_ctl      = '{op: tswc_pkg::CNT_NONE, init_term: 1'b0};
        cnt_addr     = '0;
        walk_go      = 1'b0;
        walk_from    = '0;
        surv_n       = r_n;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind = i_item.kind;
                    n_sym  = i_item.symbol;
                    n_end  = i_item.word_end;
                    n_q    = i_item.query_node;
                    case (i_item.kind)
                        tswc_pkg::IK_DICT: begin
                            if (r_werr != tswc_pkg::STS_OK ||
                                r_depth >= CW'(ACTIVE_MAX)) begin
                                // Refused character of a discarded word
                                n_valid = 1'b1;
                                n_res   = '{result_kind: tswc_pkg::RK_ACK,
                                            result_node: 10'd0, result_count: 32'd0,
                                            status: (r_werr != tswc_pkg::STS_OK) ?
                                                    r_werr : tswc_pkg::STS_LONG,
                                            last_result: 1'b1};
                                n_werr  = (r_werr != tswc_pkg::STS_OK) ?
                                          r_werr : tswc_pkg::STS_LONG;
                                if (i_item.word_end) begin
                                    n_cursor = '0;
                                    n_depth  = '0;
                                    n_werr   = tswc_pkg::STS_OK;
                                end
                            end else begin
                                walk_go   = 1'b1;
                                walk_from = r_cursor;
                            end
                        end
                        tswc_pkg::IK_STREAM: begin
                            n_i       = '0;
                            n_n       = '0;
                            walk_go   = 1'b1;
                            walk_from = (r_ac != '0) ? r_act[0] : '0;
                        end
                        tswc_pkg::IK_READ: begin
                            // Root and unused nodes never hold a count
                            if (i_item.query_node != 10'd0 &&
                                32'(i_item.query_node) < 32'(r_used)) begin
                                cnt_ctl  = '{op: tswc_pkg::CNT_READ, init_term: 1'b0};
                                cnt_addr = NW'(i_item.query_node);
                                n_state  = S_QRD;
                            end else begin
                                n_valid = 1'b1;
                                n_res   = '{result_kind: tswc_pkg::RK_COUNT,
                                            result_node: i_item.query_node,
                                            result_count: 32'd0,
                                            status: tswc_pkg::STS_OK, last_result: 1'b1};
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PAR: begin
                n_par   = r_link_q;
                n_c     = r_link_q.fc;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_c == '0) begin
                    n_found = 1'b0;
                    n_state = S_WDONE;
                end else begin
                    link_rd      = 1'b1;
                    link_rd_addr = r_c;
                    n_state      = S_SIB;
                end
            end
            S_SIB: begin
                if (r_link_q.letter == r_sym) begin
                    n_found = 1'b1;
                    n_state = S_WDONE;
                end else begin
                    n_c     = r_link_q.sib;
                    n_state = S_CHK;
                end
            end
            S_WDONE: begin
                if (r_kind == tswc_pkg::IK_DICT) begin
                    if (r_found) begin
                        if (r_end) begin
                            cnt_ctl  = '{op: tswc_pkg::CNT_READ, init_term: 1'b0};
                            cnt_addr = r_c;
                            n_state  = S_DTRM;
                        end else begin
                            n_cursor = r_c;
                            n_depth  = r_depth + CW'(1);
                            n_valid  = 1'b1;
                            n_res    = '{result_kind: tswc_pkg::RK_ACK,
                                         result_node: 10'(r_c), result_count: 32'd0,
                                         status: tswc_pkg::STS_OK, last_result: 1'b1};
                            n_state  = S_IDLE;
                        end
                    end else if (r_used >= UW'(NODE_SLOTS)) begin
                        n_valid = 1'b1;
                        n_res   = '{result_kind: tswc_pkg::RK_ACK, result_node: 10'd0,
                                    result_count: 32'd0, status: tswc_pkg::STS_FULL,
                                    last_result: 1'b1};
                        n_werr  = r_end ? tswc_pkg::STS_OK : tswc_pkg::STS_FULL;
                        if (r_end) begin
                            n_cursor = '0;
                            n_depth  = '0;
                        end
                        n_state = S_IDLE;
                    end else begin
                        // New node prepended to the parent's child list
                        link_wr      = 1'b1;
                        link_wr_addr = new_node;
                        link_wr_data = '{letter: r_sym, fc: '0, sib: parent_fc};
                        cnt_ctl      = '{op: tswc_pkg::CNT_INIT, init_term: r_end};
                        cnt_addr     = new_node;
                        n_used       = r_used + UW'(1);
                        n_new        = new_node;
                        if (r_cursor == '0) begin
                            n_root_fc = new_node;
                            n_valid   = 1'b1;
                            n_res     = '{result_kind: tswc_pkg::RK_ACK,
                                          result_node: 10'(new_node), result_count: 32'd0,
                                          status: tswc_pkg::STS_OK, last_result: 1'b1};
                            n_cursor  = r_end ? '0 : new_node;
                            n_depth   = r_end ? '0 : r_depth + CW'(1);
                            n_state   = S_IDLE;
                        end else begin
                            n_state = S_DLINK;
                        end
                    end
                end else begin
                    // Collect survivors in place; write index never passes read index
                    if (r_found && r_n < CW'(ACTIVE_MAX)) begin
                        n_act[r_n[AW-1:0]] = r_c;
                        surv_n             = r_n + CW'(1);
                    end
                    n_n = surv_n;
                    if (r_i == r_ac) begin
                        n_ac     = surv_n;
                        n_j      = '0;
                        n_pend_v = 1'b0;
                        n_state  = S_CNT;
                    end else begin
                        n_i       = nxt_i;
                        walk_go   = 1'b1;
                        walk_from = (nxt_i < r_ac) ? r_act[nxt_i[AW-1:0]] : '0;
                    end
                end
            end
            S_DLINK: begin
                link_wr      = 1'b1;
                link_wr_addr = r_cursor;
                link_wr_data = '{letter: r_par.letter, fc: r_new, sib: r_par.sib};
                n_valid      = 1'b1;
                n_res        = '{result_kind: tswc_pkg::RK_ACK, result_node: 10'(r_new),
                                 result_count: 32'd0, status: tswc_pkg::STS_OK,
                                 last_result: 1'b1};
                n_cursor     = r_end ? '0 : r_new;
                n_depth      = r_end ? '0 : r_depth + CW'(1);
                n_state      = S_IDLE;
            end
            S_DTRM: begin
                cnt_ctl  = '{op: tswc_pkg::CNT_MARK, init_term: 1'b0};
                cnt_addr = r_c;
                n_valid  = 1'b1;
                n_res    = '{result_kind: tswc_pkg::RK_ACK, result_node: 10'(r_c),
                             result_count: 32'd0, status: tswc_pkg::STS_OK,
                             last_result: 1'b1};
                n_cursor = '0;
                n_depth  = '0;
                n_state  = S_IDLE;
            end
            S_CNT: begin
                if (r_j == r_ac) begin
                    n_valid = 1'b1;
                    if (r_pend_v) begin
                        n_res = '{result_kind: tswc_pkg::RK_MATCH,
                                  result_node: 10'(r_pend_node), result_count: r_pend_cnt,
                                  status: tswc_pkg::STS_OK, last_result: 1'b1};
                    end else begin
                        n_res = '{result_kind: tswc_pkg::RK_NOMATCH, result_node: 10'd0,
                                  result_count: 32'd0, status: tswc_pkg::STS_OK,
                                  last_result: 1'b1};
                    end
                    n_state = S_IDLE;
                end else begin
                    cnt_ctl  = '{op: tswc_pkg::CNT_READ, init_term: 1'b0};
                    cnt_addr = act_j;
                    n_state  = S_CNT1;
                end
            end
            S_CNT1: begin
                if (cnt_q.term) begin
                    cnt_ctl  = '{op: tswc_pkg::CNT_BUMP, init_term: 1'b0};
                    cnt_addr = act_j;
                    // Earlier match goes out now that a later one exists
                    if (r_pend_v) begin
                        n_valid = 1'b1;
                        n_res   = '{result_kind: tswc_pkg::RK_MATCH,
                                    result_node: 10'(r_pend_node), result_count: r_pend_cnt,
                                    status: tswc_pkg::STS_OK, last_result: 1'b0};
                    end
                    n_state = S_CNT2;
                end else begin
                    n_j     = r_j + CW'(1);
                    n_state = S_CNT;
                end
            end
            S_CNT2: begin
                n_pend_v    = 1'b1;
                n_pend_node = act_j;
                n_pend_cnt  = cnt_q.cnt;
                n_j         = r_j + CW'(1);
                n_state     = S_CNT;
            end
            S_QRD: begin
                n_valid = 1'b1;
                n_res   = '{result_kind: tswc_pkg::RK_COUNT, result_node: r_q,
                            result_count: cnt_q.cnt, status: tswc_pkg::STS_OK,
                            last_result: 1'b1};
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Child search start: root links live in a register
        if (walk_go) begin
            if (walk_from == '0) begin
                n_c     = r_root_fc;
                n_state = S_CHK;
            end else begin
                link_rd      = 1'b1;
                link_rd_addr = walk_from;
                n_state      = S_PAR;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= UW'(1);
            r_cursor  <= '0;
            r_depth   <= '0;
            r_werr    <= tswc_pkg::STS_OK;
            r_root_fc <= '0;
            r_ac      <= '0;
            r_valid   <= 1'b0;
            r_pend_v  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_cursor  <= n_cursor;
            r_depth   <= n_depth;
            r_werr    <= n_werr;
            r_root_fc <= n_root_fc;
            r_ac      <= n_ac;
            r_valid   <= n_valid;
            r_pend_v  <= n_pend_v;
        end
    end

    // Payload and work registers
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_sym       <= n_sym;
        r_end       <= n_end;
        r_q         <= n_q;
        r_act       <= n_act;
        r_i         <= n_i;
        r_n         <= n_n;
        r_j         <= n_j;
        r_c         <= n_c;
        r_par       <= n_par;
        r_found     <= n_found;
        r_new       <= n_new;
        r_pend_node <= n_pend_node;
        r_pend_cnt  <= n_pend_cnt;
        r_res       <= n_res;
    end

    // Checks
    `TSWC_ASSERT(a_used_bound, r_used <= UW'(NODE_SLOTS) && r_used != '0,
                 "node count out of range")
    `TSWC_ASSERT(a_active_bound, r_ac <= CW'(ACTIVE_MAX), "active list overflow")
    `TSWC_ASSERT(a_mid_is_match,
                 !(r_valid && !r_res.last_result) || r_res.result_kind == tswc_pkg::RK_MATCH,
                 "non-final result is not a match")
    `TSWC_ASSERT_NEXT(a_stream_busy,
                      start && !busy && i_item.kind == tswc_pkg::IK_STREAM, busy,
                      "stream item did not start a walk")

endmodule

// File: sim/trie_stream_word_counter_tb.sv
// Self-checking testbench for the trie stream word counter: directed table, then random traffic.
module trie_stream_word_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS    = 1024;
    localparam int DEPTH    = 16;
    localparam int N_RANDOM = 310;
    localparam int CALM_TAIL = 60;
    localparam int STALL_LIMIT = 60000;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    tswc_pkg::t_item i_item;
    logic            o_valid;
    tswc_pkg::t_res  o_res;

    trie_stream_word_counter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    // Shadow copy of the node table and match state
    logic [7:0]  sh_letter [SLOTS];
    logic [9:0]  sh_child  [SLOTS];
    logic [9:0]  sh_sib    [SLOTS];
    logic        sh_term   [SLOTS];
    logic [31:0] sh_cnt    [SLOTS];
    logic [10:0] sh_used;
    logic [9:0]  sh_cursor;
    logic [4:0]  sh_depth;
    logic [1:0]  sh_werr;
    logic [9:0]  sh_active [DEPTH];
    logic [4:0]  sh_nactive;

    tswc_pkg::t_res pending_q[$];
    bit   failed;
    int   idle_cycles;

    typedef struct {
        tswc_pkg::t_item it;
        bit              typed;
        tswc_pkg::t_res  want;
    } t_dir_row;

    t_dir_row dir_tab[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic tswc_pkg::t_item mk_item(logic [1:0] k, logic [7:0] s, logic e,
                                                logic [9:0] q);
        tswc_pkg::t_item it;
        it.kind = k;
        it.symbol = s;
        it.word_end = e;
        it.query_node = q;
        return it;
    endfunction

    function automatic tswc_pkg::t_res mk_res(logic [1:0] k, logic [9:0] n, logic [31:0] c,
                                              logic [1:0] s, logic l);
        tswc_pkg::t_res r;
        r.result_kind = k;
        r.result_node = n;
        r.result_count = c;
        r.status = s;
        r.last_result = l;
        return r;
    endfunction

    // Append one expected result
    function automatic void expect_res(tswc_pkg::t_res r);
        pending_q = {pending_q, r};
    endfunction

    function automatic void add_row(tswc_pkg::t_item it, bit typed, tswc_pkg::t_res want);
        t_dir_row r;
        r.it = it;
        r.typed = typed;
        r.want = want;
        dir_tab = {dir_tab, r};
    endfunction

    function automatic void trie_clear();
        for (int i = 0; i < SLOTS; i++) begin
            sh_term[i] = 1'b0;
            sh_cnt[i] = '0;
        end
        sh_child[0] = '0;
        sh_used = 11'd1;
        sh_cursor = '0;
        sh_depth = '0;
        sh_werr = tswc_pkg::STS_OK;
        sh_nactive = '0;
    endfunction

    // Child of a node holding a letter, 0 when none
    function automatic logic [9:0] child_with(logic [9:0] parent, logic [7:0] sym);
        logic [9:0] c;
        int steps;
        c = sh_child[parent];
        steps = 0;
        while (c != 0 && steps < SLOTS) begin
            if (sh_letter[c] == sym) return c;
            c = sh_sib[c];
            steps++;
        end
        return '0;
    endfunction

    // Apply one transaction to the shadow state and queue its results
    function automatic int predict_results(tswc_pkg::t_item it);
        logic [9:0] node, c, from;
        logic [9:0] fresh [DEPTH];
        int n, k;
        n = 0;
        k = 0;
        case (it.kind)
            tswc_pkg::IK_DICT: begin
                node = '0;
                if (sh_werr == tswc_pkg::STS_OK) begin
                    if (sh_depth >= DEPTH) begin
                        sh_werr = tswc_pkg::STS_LONG;
                    end else begin
                        node = child_with(sh_cursor, it.symbol);
                        if (node == 0) begin
                            if (sh_used >= SLOTS) begin
                                sh_werr = tswc_pkg::STS_FULL;
                            end else begin
                                node = sh_used[9:0];
                                sh_used++;
                                sh_letter[node] = it.symbol;
                                sh_child[node] = '0;
                                sh_sib[node] = sh_child[sh_cursor];
                                sh_child[sh_cursor] = node;
                            end
                        end
                        if (sh_werr == tswc_pkg::STS_OK) begin
                            sh_cursor = node;
                            sh_depth++;
                        end
                    end
                end
                if (sh_werr != tswc_pkg::STS_OK) node = '0;
                else if (it.word_end) sh_term[node] = 1'b1;
                expect_res(mk_res(tswc_pkg::RK_ACK, node, 32'd0, sh_werr, 1'b1));
                if (it.word_end) begin
                    sh_cursor = '0;
                    sh_depth = '0;
                    sh_werr = tswc_pkg::STS_OK;
                end
                return 1;
            end
            tswc_pkg::IK_STREAM: begin
                // old matches in order, then the root
                for (int i = 0; i <= sh_nactive; i++) begin
                    from = (i < sh_nactive) ? sh_active[i] : '0;
                    c = child_with(from, it.symbol);
                    if (c != 0 && n < DEPTH) begin
                        fresh[n] = c;
                        n++;
                    end
                end
                for (int i = 0; i < n; i++) begin
                    sh_active[i] = fresh[i];
                    if (sh_term[fresh[i]]) begin
                        if (sh_cnt[fresh[i]] != 32'hFFFF_FFFF) sh_cnt[fresh[i]]++;
                        expect_res(mk_res(tswc_pkg::RK_MATCH, fresh[i], sh_cnt[fresh[i]],
                                          tswc_pkg::STS_OK, 1'b0));
                        k++;
                    end
                end
                sh_nactive = n[4:0];
                if (k == 0) begin
                    expect_res(mk_res(tswc_pkg::RK_NOMATCH, 10'd0, 32'd0,
                                      tswc_pkg::STS_OK, 1'b1));
                    return 1;
                end
                pending_q[pending_q.size() - 1].last_result = 1'b1;
                return k;
            end
            tswc_pkg::IK_READ: begin
                expect_res(mk_res(tswc_pkg::RK_COUNT, it.query_node, sh_cnt[it.query_node],
                                  tswc_pkg::STS_OK, 1'b1));
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    // Present one transaction and hold it until the block takes it
    task automatic issue(tswc_pkg::t_item it);
        i_item <= it;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic maybe_idle(bit calm);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return 8'h61 + 8'($urandom_range(0, 3));
    endfunction

    // Result checker: every strobe is matched against the oldest expectation
    always @(posedge i_clk) begin
        tswc_pkg::t_res want;
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result kind=%0d node=%0d", o_res.result_kind,
                       o_res.result_node);
                failed = 1'b1;
            end else begin
                want = pending_q.pop_front();
                if (o_res.result_kind !== want.result_kind) begin
                    $error("result_kind exp %0d got %0d", want.result_kind, o_res.result_kind);
                    failed = 1'b1;
                end
                if (o_res.result_node !== want.result_node) begin
                    $error("result_node exp %0d got %0d", want.result_node, o_res.result_node);
                    failed = 1'b1;
                end
                if (o_res.result_count !== want.result_count) begin
                    $error("result_count exp %0d got %0d", want.result_count,
                           o_res.result_count);
                    failed = 1'b1;
                end
                if (o_res.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, o_res.status);
                    failed = 1'b1;
                end
                if (o_res.last_result !== want.last_result) begin
                    $error("last_result exp %0d got %0d", want.last_result,
                           o_res.last_result);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        tswc_pkg::t_item it;
        int n, word_len, word_left;
        logic [7:0] word_sym;
        bit calm;
        failed = 1'b0;
        idle_cycles = 0;
        start = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        trie_clear();

        // Directed: empty table, extreme letters and node indexes, ignored kind
        add_row(mk_item(tswc_pkg::IK_READ, 8'h00, 1'b0, 10'd0), 1'b1,
                mk_res(tswc_pkg::RK_COUNT, 10'd0, 32'd0, tswc_pkg::STS_OK, 1'b1));
        add_row(mk_item(tswc_pkg::IK_READ, 8'hff, 1'b1, 10'd1023), 1'b1,
                mk_res(tswc_pkg::RK_COUNT, 10'd1023, 32'd0, tswc_pkg::STS_OK, 1'b1));
        add_row(mk_item(tswc_pkg::IK_STREAM, 8'h78, 1'b0, 10'd0), 1'b1,
                mk_res(tswc_pkg::RK_NOMATCH, 10'd0, 32'd0, tswc_pkg::STS_OK, 1'b1));
        add_row(mk_item(tswc_pkg::IK_DICT, 8'h61, 1'b0, 10'd0), 1'b1,
                mk_res(tswc_pkg::RK_ACK, 10'd1, 32'd0, tswc_pkg::STS_OK, 1'b1));
        add_row(mk_item(tswc_pkg::IK_DICT, 8'h62, 1'b1, 10'd0), 1'b1,
                mk_res(tswc_pkg::RK_ACK, 10'd2, 32'd0, tswc_pkg::STS_OK, 1'b1));
        add_row(mk_item(tswc_pkg::IK_DICT, 8'hff, 1'b1, 10'h3ff), 1'b1,
                mk_res(tswc_pkg::RK_ACK, 10'd3, 32'd0, tswc_pkg::STS_OK, 1'b1));
        add_row(mk_item(tswc_pkg::IK_DICT, 8'h00, 1'b1, 10'd0), 1'b1,
                mk_res(tswc_pkg::RK_ACK, 10'd4, 32'd0, tswc_pkg::STS_OK, 1'b1));
        add_row(mk_item(tswc_pkg::IK_DICT, 8'h61, 1'b1, 10'd0), 1'b1,
                mk_res(tswc_pkg::RK_ACK, 10'd1, 32'd0, tswc_pkg::STS_OK, 1'b1));
        add_row(mk_item(tswc_pkg::IK_STREAM, 8'h61, 1'b0, 10'd0), 1'b0, '0);
        add_row(mk_item(tswc_pkg::IK_STREAM, 8'h62, 1'b0, 10'd0), 1'b0, '0);
        add_row(mk_item(tswc_pkg::IK_STREAM, 8'hff, 1'b1, 10'h3ff), 1'b0, '0);
        add_row(mk_item(tswc_pkg::IK_STREAM, 8'h00, 1'b0, 10'd0), 1'b0, '0);
        add_row(mk_item(2'd3, 8'h55, 1'b1, 10'h2aa), 1'b0, '0);
        add_row(mk_item(tswc_pkg::IK_READ, 8'h00, 1'b0, 10'd2), 1'b0, '0);
        add_row(mk_item(tswc_pkg::IK_READ, 8'h00, 1'b0, 10'd1), 1'b0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            n = predict_results(dir_tab[r].it);
            if (dir_tab[r].typed) begin
                repeat (n) void'(pending_q.pop_back());
                expect_res(dir_tab[r].want);
            end
            issue(dir_tab[r].it);
            maybe_idle(1'b0);
        end

        // Random: mostly whole words and streams over a small alphabet
        word_left = 0;
        word_sym = 8'h61;
        n = 0;
        while (n < N_RANDOM) begin
            calm = (n >= N_RANDOM - CALM_TAIL);
            if (n == N_RANDOM / 2) begin
                start <= 1'b0;
                while (pending_q.size() != 0) @(posedge i_clk);
            end
            if (word_left > 0) begin
                // long words repeat one letter to build deep match chains
                it = mk_item(tswc_pkg::IK_DICT, (word_len > 12) ? word_sym : pick_letter(),
                             word_left == 1, 10'($urandom));
                word_left--;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: begin
                        word_len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 19)
                                                              : $urandom_range(1, 5);
                        word_sym = pick_letter();
                        word_left = word_len - 1;
                        it = mk_item(tswc_pkg::IK_DICT,
                                     (word_len > 12) ? word_sym : pick_letter(),
                                     word_len == 1, 10'($urandom));
                    end
                    4, 5: it = mk_item(tswc_pkg::IK_READ, 8'($urandom), 1'($urandom),
                                       ($urandom_range(0, 1) == 0) ? 10'($urandom)
                                           : 10'($urandom_range(0, sh_used - 1)));
                    6: it = mk_item(2'd3, 8'($urandom), 1'($urandom), 10'($urandom));
                    default: it = mk_item(tswc_pkg::IK_STREAM, pick_letter(), 1'($urandom),
                                          10'($urandom));
                endcase
            end
            if (predict_results(it) != 0) n++;
            issue(it);
            maybe_idle(calm);
        end

        // Closing burst of reads and stream characters with no gaps
        for (int i = 0; i < 20; i++) begin
            it = mk_item(($urandom_range(0, 2) == 0) ? tswc_pkg::IK_READ : tswc_pkg::IK_STREAM,
                         8'($urandom), 1'b0, 10'($urandom));
            void'(predict_results(it));
            issue(it);
        end
        start <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (!failed) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
